>>> hw/rtl/simpson_odometer_integrator_assert.svh
// ----------------------------------------------------------------------------
// Simpson odometer integrator assertion macros
// Shorthand for the concurrent checks on the integrator's ports.
// ----------------------------------------------------------------------------
`ifndef SIMPSON_ODOMETER_INTEGRATOR_ASSERT_SVH
`define SIMPSON_ODOMETER_INTEGRATOR_ASSERT_SVH

// Checks the consequent in the cycle after the antecedent, outside reset.
`define SOI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

// Checks that the consequent holds in the same cycle as the antecedent, outside reset.
`define SOI_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Checks a next-cycle implication that also covers the reset cycles.
`define SOI_ASSERT_NEXT_ANY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/soi_pkg.sv
// ----------------------------------------------------------------------------
// Simpson odometer integrator package
// Shared types, codes and fixed widths of the odometer integrator.
// ----------------------------------------------------------------------------
package soi_pkg;

  localparam int KIND_W    = 2;
  localparam int SPEED_W   = 24;
  localparam int METER_W   = 30;
  localparam int SESSION_W = 32;
  localparam int STEP_W    = 16;
  localparam int SCALE_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 30;

  localparam int ALU_W     = 65;
  localparam int ODO_Q_W   = 62;
  localparam int SESS_Q_W  = 64;
  localparam int FRAC_W    = 32;

  localparam int MUL_STEPS = SCALE_W;
  localparam int DIV_STEPS = METER_W;
  localparam int CNT_W     = 5;

  localparam logic [METER_W-1:0] TRIP_LIMIT_RST = 30'd1000000;
  localparam logic [METER_W-1:0] ODO_LIMIT_RST  = 30'd999999009;
  localparam logic [STEP_W-1:0]  SAVE_STEP_RST  = 16'd100;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 24'd77672;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPEED    = 2'd0,
    KIND_CLR_TRIP = 2'd1,
    KIND_CLR_ALL  = 2'd2,
    KIND_LOAD     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIP_LIMIT = 2'd0,
    REG_ODO_LIMIT  = 2'd1,
    REG_SAVE_STEP  = 2'd2,
    REG_SCALE      = 2'd3
  } reg_idx_t;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_ACC      = 12'b0000_0000_0010,
    ST_MUL      = 12'b0000_0000_0100,
    ST_ODO      = 12'b0000_0000_1000,
    ST_ODO_LIM  = 12'b0000_0001_0000,
    ST_TRIP     = 12'b0000_0010_0000,
    ST_TRIP_LIM = 12'b0000_0100_0000,
    ST_SESS     = 12'b0000_1000_0000,
    ST_SESS_SAT = 12'b0001_0000_0000,
    ST_DIV      = 12'b0010_0000_0000,
    ST_BUCKET   = 12'b0100_0000_0000,
    ST_OUT      = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic  in_fire;
    kind_t kind;
    logic  win_close;
    logic  out_free;
  } soi_sts_t;

  typedef struct packed {
    state_t st;
    logic   idle;
  } soi_ctl_t;

endpackage

>>> hw/rtl/soi_alu.sv
// ----------------------------------------------------------------------------
// Simpson odometer integrator shared adder
// One wide add/subtract unit reused by every arithmetic step.
// ----------------------------------------------------------------------------
module soi_alu (
  input  logic [soi_pkg::ALU_W-1:0] a,
  input  logic [soi_pkg::ALU_W-1:0] b,
  input  logic                      sub,
  output logic [soi_pkg::ALU_W-1:0] y
);
  import soi_pkg::*;

  logic [ALU_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign y    = a + b_op + {{(ALU_W-1){1'b0}}, sub};

endmodule

>>> hw/rtl/soi_seq.sv
// ----------------------------------------------------------------------------
// Simpson odometer integrator sequencer
// Steps a word through the accumulate, multiply, totals and bucket divide it needs.
// ----------------------------------------------------------------------------
module soi_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  soi_pkg::soi_sts_t sts,
  output soi_pkg::soi_ctl_t ctl
);
  import soi_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.in_fire) begin
          unique case (sts.kind)
            KIND_SPEED:    state_nxt = ST_ACC;
            KIND_CLR_TRIP: state_nxt = ST_OUT;
            KIND_CLR_ALL:  state_nxt = ST_OUT;
            KIND_LOAD:     state_nxt = ST_DIV;
            default:       state_nxt = ST_OUT;
          endcase
        end
      end
      ST_ACC:      state_nxt = sts.win_close ? ST_MUL : ST_OUT;
      ST_MUL:      if (cnt_r == CNT_W'(MUL_STEPS - 1)) state_nxt = ST_ODO;
      ST_ODO:      state_nxt = ST_ODO_LIM;
      ST_ODO_LIM:  state_nxt = ST_TRIP;
      ST_TRIP:     state_nxt = ST_TRIP_LIM;
      ST_TRIP_LIM: state_nxt = ST_SESS;
      ST_SESS:     state_nxt = ST_SESS_SAT;
      ST_SESS_SAT: state_nxt = ST_DIV;
      ST_DIV:      if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_BUCKET;
      ST_BUCKET:   state_nxt = ST_OUT;
      ST_OUT:      if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  assign cnt_nxt = ((state_r == ST_MUL) || (state_r == ST_DIV)) ? cnt_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign ctl.st   = state_r;
  assign ctl.idle = (state_r == ST_IDLE);

endmodule

>>> hw/rtl/simpson_odometer_integrator.sv
// ----------------------------------------------------------------------------
// Simpson odometer integrator
// Integrates speed words by Simpson's rule into odometer, trip and session
// totals, with trip bucket tracking for save requests.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one word per item (speed sample, clear trip,
// clear odometer and trip, or load totals); every item yields one result word
// on the output channel. Configuration writes go over the cfg channel, which
// is always ready; the user must make them only while the block is idle, as
// the block itself does not enforce this. A clear goes straight to the
// output, a sample that does not close a window only accumulates, a load
// runs the bucket divide, and a sample that closes a window runs the
// multiply, the total updates and the bucket divide. The result word turns
// valid in the same cycle as the block returns to idle. The shared adder
// works in steps: 24 shift-add passes for the distance multiply, an add and a
// limit step for each of the three total updates, and 30 restoring-division
// passes for the trip bucket. in_stall is high from acceptance until the
// block returns to idle, so one item is in work at a time. The result sits in
// an output register; a new item is accepted while it waits, but that item's
// result waits until the receiver lowers out_stall. Reset clears the totals,
// the window and the output valid, and restores the register defaults.
// ----------------------------------------------------------------------------
module simpson_odometer_integrator #(
  parameter int SAMPLES_PER_WINDOW = 21
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [soi_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [soi_pkg::SPEED_W-1:0] in_speed_kmh_q8,
  input  logic [soi_pkg::METER_W-1:0]        in_load_odo_m,
  input  logic [soi_pkg::METER_W-1:0]        in_load_trip_m,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [soi_pkg::METER_W-1:0]        out_odo_m,
  output logic [soi_pkg::METER_W-1:0]        out_trip_m,
  output logic [soi_pkg::SESSION_W-1:0]      out_session_m,
  output logic                               out_window_done,
  output logic                               out_save_request,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [soi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [soi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import soi_pkg::*;

  localparam int IDX_W  = $clog2(SAMPLES_PER_WINDOW);
  localparam int SUM_W  = 25 + $clog2(SAMPLES_PER_WINDOW);
  localparam int PROD_W = SUM_W + SCALE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_WINDOW - 1);

  logic [METER_W-1:0] trip_lim_r, odo_lim_r;
  logic [STEP_W-1:0]  step_r;
  logic [SCALE_W-1:0] scale_r;

  logic [IDX_W-1:0]    idx_r;
  logic [SUM_W-1:0]    wsum_r;
  logic [SPEED_W-2:0]  spd_r;
  logic [PROD_W-1:0]   mcand_r, prod_r;
  logic [SCALE_W-1:0]  mplier_r;
  logic [ALU_W-1:0]    sum_r;
  logic [ODO_Q_W-1:0]  odo_r, trip_r;
  logic [SESS_Q_W-1:0] sess_r;
  logic [METER_W-1:0]  quo_r, lastb_r;
  logic [STEP_W-1:0]   rem_r;
  logic                force_r, done_r, save_r;
  logic                out_valid_r;

  soi_sts_t sts;
  soi_ctl_t ctl;
  kind_t    kind;

  logic [SPEED_W-2:0]  v_in;
  logic [SPEED_W:0]    v_w;
  logic [STEP_W-1:0]   step_eff;
  logic [STEP_W:0]     div_a;
  logic [ALU_W-1:0]    alu_a, alu_b, alu_y;
  logic                alu_sub;
  logic                win_close, out_free, in_fire, changed;
  logic [ODO_Q_W-1:0]  odo_lim_q, trip_lim_q;
  logic [METER_W-1:0]  odo_ld, trip_ld;

  assign kind      = kind_t'(in_kind);
  assign in_fire   = in_valid && ctl.idle;
  assign in_stall  = !ctl.idle;
  assign out_free  = !out_valid_r || !out_stall;
  assign win_close = (idx_r == LAST_IDX);
  assign cfg_ready = 1'b1;

  assign sts.in_fire   = in_fire;
  assign sts.kind      = kind;
  assign sts.win_close = win_close;
  assign sts.out_free  = out_free;

  soi_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_lim_r <= TRIP_LIMIT_RST;
      odo_lim_r  <= ODO_LIMIT_RST;
      step_r     <= SAVE_STEP_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TRIP_LIMIT: trip_lim_r <= cfg_data[METER_W-1:0];
        REG_ODO_LIMIT:  odo_lim_r  <= cfg_data[METER_W-1:0];
        REG_SAVE_STEP:  step_r     <= cfg_data[STEP_W-1:0];
        REG_SCALE:      scale_r    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign v_in     = in_speed_kmh_q8[SPEED_W-1] ? '0 : in_speed_kmh_q8[SPEED_W-2:0];
  assign step_eff = (step_r == '0) ? STEP_W'(1) : step_r;
  assign div_a    = {rem_r, quo_r[METER_W-1]};
  assign odo_lim_q  = {odo_lim_r, {FRAC_W{1'b0}}};
  assign trip_lim_q = {trip_lim_r, {FRAC_W{1'b0}}};
  assign odo_ld   = (in_load_odo_m > odo_lim_r) ? odo_lim_r : in_load_odo_m;
  assign trip_ld  = (in_load_trip_m > trip_lim_r) ? '0 : in_load_trip_m;
  assign changed  = force_r || (quo_r != lastb_r);

  always_comb begin
    if ((idx_r == '0) || (idx_r == LAST_IDX)) begin
      v_w = {2'b00, spd_r};
    end else if (idx_r[0]) begin
      v_w = {spd_r, 2'b00};
    end else begin
      v_w = {1'b0, spd_r, 1'b0};
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (ctl.st)
      ST_ACC: begin
        alu_a = ALU_W'(wsum_r);
        alu_b = ALU_W'(v_w);
      end
      ST_MUL: begin
        alu_a = ALU_W'(prod_r);
        alu_b = mplier_r[0] ? ALU_W'(mcand_r) : '0;
      end
      ST_ODO: begin
        alu_a = ALU_W'(odo_r);
        alu_b = ALU_W'(prod_r);
      end
      ST_TRIP: begin
        alu_a = ALU_W'(trip_r);
        alu_b = ALU_W'(prod_r);
      end
      ST_SESS: begin
        alu_a = ALU_W'(sess_r);
        alu_b = ALU_W'(prod_r);
      end
      ST_DIV: begin
        alu_a   = ALU_W'(div_a);
        alu_b   = ALU_W'(step_eff);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  soi_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  // Window and total state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      wsum_r  <= '0;
      odo_r   <= '0;
      trip_r  <= '0;
      sess_r  <= '0;
      lastb_r <= '0;
      force_r <= 1'b0;
      done_r  <= 1'b0;
      save_r  <= 1'b0;
    end else begin
      unique case (ctl.st)
        ST_IDLE: begin
          if (in_fire) begin
            spd_r  <= v_in;
            done_r <= 1'b0;
            save_r <= 1'b1;
            unique case (kind)
              KIND_SPEED: ;
              KIND_CLR_TRIP: begin
                trip_r  <= '0;
                lastb_r <= '0;
              end
              KIND_CLR_ALL: begin
                odo_r   <= '0;
                trip_r  <= '0;
                lastb_r <= '0;
              end
              KIND_LOAD: begin
                odo_r   <= {odo_ld, {FRAC_W{1'b0}}};
                trip_r  <= {trip_ld, {FRAC_W{1'b0}}};
                quo_r   <= trip_ld;
                rem_r   <= '0;
                force_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_ACC: begin
          wsum_r <= alu_y[SUM_W-1:0];
          done_r <= win_close;
          save_r <= 1'b0;
          if (win_close) begin
            idx_r    <= IDX_W'(1);
            mcand_r  <= PROD_W'(alu_y[SUM_W-1:0]);
            mplier_r <= scale_r;
            prod_r   <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_MUL: begin
          prod_r   <= alu_y[PROD_W-1:0];
          mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[SCALE_W-1:1]};
        end
        ST_ODO: begin
          sum_r  <= alu_y;
          wsum_r <= SUM_W'(spd_r);
        end
        ST_ODO_LIM: begin
          odo_r <= (sum_r > ALU_W'(odo_lim_q)) ? odo_lim_q : sum_r[ODO_Q_W-1:0];
        end
        ST_TRIP: sum_r <= alu_y;
        ST_TRIP_LIM: begin
          trip_r <= (sum_r > ALU_W'(trip_lim_q)) ? '0 : sum_r[ODO_Q_W-1:0];
        end
        ST_SESS: sum_r <= alu_y;
        ST_SESS_SAT: begin
          sess_r  <= sum_r[ALU_W-1] ? '1 : sum_r[SESS_Q_W-1:0];
          quo_r   <= trip_r[ODO_Q_W-1:FRAC_W];
          rem_r   <= '0;
          force_r <= 1'b0;
        end
        ST_DIV: begin
          rem_r <= alu_y[ALU_W-1] ? div_a[STEP_W-1:0] : alu_y[STEP_W-1:0];
          quo_r <= {quo_r[METER_W-2:0], ~alu_y[ALU_W-1]};
        end
        ST_BUCKET: begin
          save_r  <= changed;
          force_r <= 1'b0;
          if (changed) begin
            lastb_r <= quo_r;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctl.st == ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.st == ST_OUT) && out_free) begin
      out_odo_m        <= odo_r[ODO_Q_W-1:FRAC_W];
      out_trip_m       <= trip_r[ODO_Q_W-1:FRAC_W];
      out_session_m    <= sess_r[SESS_Q_W-1:FRAC_W];
      out_window_done  <= done_r;
      out_save_request <= save_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/soi_chk.sv
// ----------------------------------------------------------------------------
// Simpson odometer integrator port checker
// Concurrent checks on the integrator's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "simpson_odometer_integrator_assert.svh"

module soi_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [soi_pkg::METER_W-1:0]        out_odo_m,
  input logic [soi_pkg::METER_W-1:0]        out_trip_m,
  input logic [soi_pkg::SESSION_W-1:0]      out_session_m,
  input logic                               out_window_done,
  input logic                               out_save_request
);
  import soi_pkg::*;

  `SOI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `SOI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_odo_m) && $stable(out_trip_m) && $stable(out_session_m) && $stable(out_window_done) && $stable(out_save_request))
  `SOI_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall))
  `SOI_ASSERT_NEXT_ANY(a_reset_no_result, !rst_n, !out_valid)

endmodule

bind simpson_odometer_integrator soi_chk u_soi_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_odo_m        (out_odo_m),
  .out_trip_m       (out_trip_m),
  .out_session_m    (out_session_m),
  .out_window_done  (out_window_done),
  .out_save_request (out_save_request)
);

>>> sim/simpson_odometer_integrator_checker.sv
// ----------------------------------------------------------------------------
// Simpson odometer integrator checker
// Watches the input, result and configuration channels of the integrator,
// predicts the totals that each accepted word must produce, and compares
// every accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module simpson_odometer_integrator_checker #(
  parameter int SAMPLES_PER_WINDOW = 21
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [soi_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [soi_pkg::SPEED_W-1:0] in_speed_kmh_q8,
  input  logic [soi_pkg::METER_W-1:0]        in_load_odo_m,
  input  logic [soi_pkg::METER_W-1:0]        in_load_trip_m,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [soi_pkg::METER_W-1:0]        out_odo_m,
  input  logic [soi_pkg::METER_W-1:0]        out_trip_m,
  input  logic [soi_pkg::SESSION_W-1:0]      out_session_m,
  input  logic                               out_window_done,
  input  logic                               out_save_request,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [soi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [soi_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 mismatches,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import soi_pkg::*;

  typedef struct packed {
    logic [METER_W-1:0]   odo_m;
    logic [METER_W-1:0]   trip_m;
    logic [SESSION_W-1:0] session_m;
    logic                 window_done;
    logic                 save_request;
  } totals_t;

  logic [METER_W-1:0] trip_limit;
  logic [METER_W-1:0] odo_limit;
  logic [STEP_W-1:0]  save_step;
  logic [SCALE_W-1:0] scale;

  int unsigned win_pos;
  logic [63:0] weighted_sum;
  logic [63:0] odo_q;
  logic [63:0] trip_q;
  logic [63:0] session_q;
  logic [31:0] last_bucket;
  bit          force_save;
  totals_t     totals_q[$];

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic logic [63:0] simpson_weight(int unsigned pos);
    if (pos == 0 || pos >= SAMPLES_PER_WINDOW - 1) return 64'd1;
    return pos[0] ? 64'd4 : 64'd2;
  endfunction

  task automatic clamp_totals();
    logic [63:0] tl;
    logic [63:0] ol;
    tl = {2'b00, trip_limit, 32'd0};
    ol = {2'b00, odo_limit, 32'd0};
    if (trip_q > tl) trip_q = 64'd0;
    if (odo_q > ol) odo_q = ol;
  endtask

  task automatic update_bucket(output logic changed);
    logic [31:0] step;
    logic [31:0] bucket;
    step = (save_step == '0) ? 32'd1 : {16'd0, save_step};
    bucket = trip_q[63:32] / step;
    changed = force_save || (bucket != last_bucket);
    force_save = 1'b0;
    if (changed) last_bucket = bucket;
  endtask

  task automatic predict_totals(kind_t k, logic [SPEED_W-1:0] spd,
                                logic [METER_W-1:0] lo, logic [METER_W-1:0] lt);
    logic [SPEED_W-1:0] v;
    logic [63:0] win_dist;
    logic [64:0] sum;
    totals_t t;
    t = '0;
    v = spd[SPEED_W-1] ? '0 : spd;
    case (k)
      KIND_SPEED: begin
        weighted_sum = weighted_sum + simpson_weight(win_pos) * {40'd0, v};
        win_pos++;
        if (win_pos >= SAMPLES_PER_WINDOW) begin
          win_dist = weighted_sum * {40'd0, scale};
          odo_q = odo_q + win_dist;
          trip_q = trip_q + win_dist;
          sum = {1'b0, session_q} + {1'b0, win_dist};
          session_q = sum[64] ? '1 : sum[63:0];
          clamp_totals();
          weighted_sum = {40'd0, v};
          win_pos = 1;
          t.window_done = 1'b1;
          update_bucket(t.save_request);
        end
      end
      KIND_CLR_TRIP: begin
        trip_q = '0;
        last_bucket = '0;
        t.save_request = 1'b1;
      end
      KIND_CLR_ALL: begin
        odo_q = '0;
        trip_q = '0;
        last_bucket = '0;
        t.save_request = 1'b1;
      end
      default: begin
        odo_q = {2'b00, lo, 32'd0};
        trip_q = {2'b00, lt, 32'd0};
        force_save = 1'b1;
        clamp_totals();
        update_bucket(t.save_request);
      end
    endcase
    t.odo_m = odo_q[61:32];
    t.trip_m = trip_q[61:32];
    t.session_m = session_q[63:32];
    totals_q.push_back(t);
  endtask

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    totals_t want;
    if (!rst_n) begin
      trip_limit = TRIP_LIMIT_RST;
      odo_limit = ODO_LIMIT_RST;
      save_step = SAVE_STEP_RST;
      scale = SCALE_RST;
      win_pos = 0;
      weighted_sum = '0;
      odo_q = '0;
      trip_q = '0;
      session_q = '0;
      last_bucket = '0;
      force_save = 1'b0;
      totals_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_TRIP_LIMIT: trip_limit = cfg_data[METER_W-1:0];
          REG_ODO_LIMIT:  odo_limit = cfg_data[METER_W-1:0];
          REG_SAVE_STEP:  save_step = cfg_data[STEP_W-1:0];
          default:        scale = cfg_data[SCALE_W-1:0];
        endcase
      end
      if (out_valid && !out_stall) begin
        if (totals_q.size() == 0) begin
          report("result word with nothing pending, odo_m", out_odo_m, 0);
        end else begin
          want = totals_q.pop_front();
          if (out_odo_m != want.odo_m) report("odo_m", out_odo_m, want.odo_m);
          if (out_trip_m != want.trip_m) report("trip_m", out_trip_m, want.trip_m);
          if (out_session_m != want.session_m)
            report("session_m", out_session_m, want.session_m);
          if (out_window_done != want.window_done)
            report("window_done", out_window_done, want.window_done);
          if (out_save_request != want.save_request)
            report("save_request", out_save_request, want.save_request);
        end
      end
      if (in_valid && !in_stall)
        predict_totals(kind_t'(in_kind), in_speed_kmh_q8, in_load_odo_m, in_load_trip_m);
    end
    outstanding <= totals_q.size();
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Simpson odometer integrator testbench
// Drives directed and random words and register settings into the
// integrator with random idle and stall periods, and gives the verdict from
// the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import soi_pkg::*;

  localparam int SAMPLES_PER_WINDOW = 21;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 190;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [KIND_W-1:0]         in_kind = '0;
  logic signed [SPEED_W-1:0] in_speed_kmh_q8 = '0;
  logic [METER_W-1:0]        in_load_odo_m = '0;
  logic [METER_W-1:0]        in_load_trip_m = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [METER_W-1:0]        out_odo_m;
  logic [METER_W-1:0]        out_trip_m;
  logic [SESSION_W-1:0]      out_session_m;
  logic                      out_window_done;
  logic                      out_save_request;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int mismatches;
  int outstanding;
  bit quiet = 1'b0;
  int stall_hold = 0;
  logic [METER_W-1:0] trip_lim = TRIP_LIMIT_RST;
  logic [METER_W-1:0] odo_lim = ODO_LIMIT_RST;

  always #6 clk = ~clk;

  simpson_odometer_integrator #(.SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW)) dut (.*);

  simpson_odometer_integrator_checker #(.SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW)) u_checker (.*);

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold <= idle_len();
    end
  end

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'h7FFFFF;
      2:       return {1'b1, 23'($urandom)};
      3, 4:    return 24'($urandom);
      default: return 24'($urandom_range(0, 51200));
    endcase
  endfunction

  function automatic logic [METER_W-1:0] pick_meters(logic [METER_W-1:0] lim);
    case ($urandom_range(0, 3))
      0:       return 30'($urandom);
      1:       return 30'($urandom_range(0, 5000));
      2:       return lim - 30'($urandom_range(0, 3));
      default: return lim + 30'($urandom_range(0, 2));
    endcase
  endfunction

  task automatic send_word(kind_t k, logic [SPEED_W-1:0] spd,
                           logic [METER_W-1:0] lo, logic [METER_W-1:0] lt);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_speed_kmh_q8 <= spd;
    in_load_odo_m <= lo;
    in_load_trip_m <= lt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(int p);
    logic [METER_W-1:0] tl;
    logic [METER_W-1:0] ol;
    logic [STEP_W-1:0]  st;
    logic [SCALE_W-1:0] sc;
    case (p)
      1: begin
        tl = 30'd1; ol = '1; st = 16'd1; sc = '1;
      end
      2: begin
        tl = '1; ol = 30'd1; st = '1; sc = 24'd1;
      end
      3: begin
        tl = '0; ol = '0; st = '0; sc = 24'($urandom);
      end
      PHASES: begin
        tl = TRIP_LIMIT_RST; ol = ODO_LIMIT_RST; st = SAVE_STEP_RST; sc = SCALE_RST;
      end
      default: begin
        tl = $urandom_range(0, 1) ? 30'($urandom_range(1, 20000)) : 30'($urandom);
        ol = $urandom_range(0, 1) ? 30'($urandom_range(1, 2000000)) : 30'($urandom);
        st = $urandom_range(0, 1) ? 16'($urandom_range(1, 500)) : 16'($urandom);
        sc = 24'($urandom);
      end
    endcase
    trip_lim = tl;
    odo_lim = ol;
    write_reg(REG_TRIP_LIMIT, tl);
    write_reg(REG_ODO_LIMIT, ol);
    write_reg(REG_SAVE_STEP, {14'd0, st});
    write_reg(REG_SCALE, {6'd0, sc});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 86)
      send_word(KIND_SPEED, pick_speed(), 30'($urandom), 30'($urandom));
    else if (r < 90)
      send_word(KIND_CLR_TRIP, 24'($urandom), 30'($urandom), 30'($urandom));
    else if (r < 92)
      send_word(KIND_CLR_ALL, 24'($urandom), 30'($urandom), 30'($urandom));
    else
      send_word(KIND_LOAD, 24'($urandom), pick_meters(odo_lim), pick_meters(trip_lim));
    if ($urandom_range(0, 199) == 0) wait_drain();
  endtask

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Clears, then loads with both totals over their limits, then one near the
    // limits so that a window of full-scale samples saturates the odometer and
    // wraps the trip. Negative samples must count as zero speed.
    send_word(KIND_CLR_TRIP, 24'h7FFFFF, '1, '1);
    send_word(KIND_CLR_ALL, 24'h800000, '1, '1);
    send_word(KIND_LOAD, '0, '1, '1);
    send_word(KIND_LOAD, '0, 30'd999999000, 30'd999999);
    send_word(KIND_SPEED, 24'h800000, '0, '0);
    send_word(KIND_SPEED, 24'h7FFFFF, '0, '0);
    send_word(KIND_SPEED, 24'hFFFFFF, '0, '0);
    for (int i = 3; i <= SAMPLES_PER_WINDOW; i++)
      send_word(KIND_SPEED, 24'h7FFFFF, '0, '0);

    for (int p = 1; p <= PHASES; p++) begin
      wait_drain();
      quiet = 1'b0;
      repeat (70) @(negedge clk);
      configure(p);
      quiet = (p % 3 == 0);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    in_valid <= 1'b0;
    quiet = 1'b1;
    @(negedge clk);
    for (int n = 0; n < 20000 && outstanding != 0; n++) @(negedge clk);
    repeat (80) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> simpson_odometer_integrator.f
+incdir+hw/rtl
hw/rtl/soi_pkg.sv
hw/rtl/soi_alu.sv
hw/rtl/soi_seq.sv
hw/rtl/simpson_odometer_integrator.sv
hw/rtl/soi_chk.sv
sim/simpson_odometer_integrator_checker.sv
sim/testbench.sv
